@@ rtl/rbsi_pkg.sv @@
// Package for the ray versus box slab test: widths, register indexes and defaults.
package rbsi_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS       = 16;
   localparam int LIMIT_WIDTH     = 31;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int NUM_AXES        = 3;
   localparam int NUM_LANES       = 2 * NUM_AXES;

   typedef logic [CSR_ADDR_WIDTH-1:0] csr_addr_type;

   localparam csr_addr_type CSR_BOX_MIN_X = 3'd0;
   localparam csr_addr_type CSR_BOX_MIN_Y = 3'd1;
   localparam csr_addr_type CSR_BOX_MIN_Z = 3'd2;
   localparam csr_addr_type CSR_BOX_MAX_X = 3'd3;
   localparam csr_addr_type CSR_BOX_MAX_Y = 3'd4;
   localparam csr_addr_type CSR_BOX_MAX_Z = 3'd5;
   localparam csr_addr_type CSR_NEAR_ZERO = 3'd6;

endpackage

@@ rtl/ray_box_slab_intersect.sv @@
// Ray versus axis-aligned box test by the slab method, pipelined, Q16.16.
//
// Usage: rays arrive on the req_ channel (valid/ready), one transaction per
// ray; each ray gives exactly one rsp_ transaction carrying hit and the
// narrowed interval [rsp_enter_param, rsp_exit_param], both zero on a miss.
// The box and the near-zero direction limit sit in registers written through
// csr_we/csr_addr/csr_wdata; write them only while no ray is in flight.
// Between req_ acceptance and rsp_ a ray passes these stages in order: one
// stage forms the slab distances, one prepares the division, COORD_WIDTH
// stages retire one quotient bit each for six dividers in parallel, one
// saturates, and three narrow the interval axis by axis. A ray may enter every
// cycle unless the pipeline is frozen (see below), so throughput is one per
// cycle.
// Reset empties the pipeline and loads an empty box (min at the largest
// value, max at the smallest) with a limit of one.
// When the receiver holds rsp_ready low with a result waiting, the whole
// pipeline freezes and req_ready drops; nothing is lost or repeated.
module ray_box_slab_intersect
   import rbsi_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [COORD_WIDTH-1:0]   req_origin_x,
   input  logic signed [COORD_WIDTH-1:0]   req_origin_y,
   input  logic signed [COORD_WIDTH-1:0]   req_origin_z,
   input  logic signed [COORD_WIDTH-1:0]   req_dir_x,
   input  logic signed [COORD_WIDTH-1:0]   req_dir_y,
   input  logic signed [COORD_WIDTH-1:0]   req_dir_z,
   input  logic signed [COORD_WIDTH-1:0]   req_interval_start,
   input  logic signed [COORD_WIDTH-1:0]   req_interval_end,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_hit,
   output logic signed [COORD_WIDTH-1:0]   rsp_enter_param,
   output logic signed [COORD_WIDTH-1:0]   rsp_exit_param,
   input  logic                            csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0]       csr_addr,
   input  logic [(COORD_WIDTH > LIMIT_WIDTH ? COORD_WIDTH : LIMIT_WIDTH)-1:0] csr_wdata
);

   localparam int W    = COORD_WIDTH;
   localparam int CMPW = (W > LIMIT_WIDTH ? W : LIMIT_WIDTH) + 1;
   localparam int DVW  = W + 1 + FRAC_BITS;
   localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0]        TOP  = {1'b1, {(W-1){1'b0}}};

   // configuration registers
   logic signed [W-1:0]     box_min_ff [NUM_AXES];
   logic signed [W-1:0]     box_max_ff [NUM_AXES];
   logic [LIMIT_WIDTH-1:0]  limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            box_min_ff[a] <= SMAX;
            box_max_ff[a] <= SMIN;
         end
         limit_ff <= LIMIT_WIDTH'(1);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_BOX_MIN_X: box_min_ff[0] <= csr_wdata[W-1:0];
            CSR_BOX_MIN_Y: box_min_ff[1] <= csr_wdata[W-1:0];
            CSR_BOX_MIN_Z: box_min_ff[2] <= csr_wdata[W-1:0];
            CSR_BOX_MAX_X: box_max_ff[0] <= csr_wdata[W-1:0];
            CSR_BOX_MAX_Y: box_max_ff[1] <= csr_wdata[W-1:0];
            CSR_BOX_MAX_Z: box_max_ff[2] <= csr_wdata[W-1:0];
            CSR_NEAR_ZERO: limit_ff      <= csr_wdata[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline advances together; freeze only when the output is stuck
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   logic signed [W-1:0] org [NUM_AXES];
   logic signed [W-1:0] dir [NUM_AXES];
   assign org[0] = req_origin_x;
   assign org[1] = req_origin_y;
   assign org[2] = req_origin_z;
   assign dir[0] = req_dir_x;
   assign dir[1] = req_dir_y;
   assign dir[2] = req_dir_z;

   // ---------------- stage 1: slab distances and direction magnitudes
   logic                v1_ff;
   logic signed [W-1:0] t0_1_ff, t1_1_ff;
   logic [W:0]          num1_ff  [NUM_LANES];
   logic                nneg1_ff [NUM_LANES];
   logic [W-1:0]        den1_ff  [NUM_AXES];
   logic                dneg1_ff [NUM_AXES];
   logic                par1_ff  [NUM_AXES];
   logic                pmiss1_ff[NUM_AXES];

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t0_1_ff <= req_interval_start;
         t1_1_ff <= req_interval_end;
      end
   end

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis1
      logic [W-1:0]    dmag;
      logic [CMPW-1:0] dmag_x, lim_x;
      assign dmag   = dir[a][W-1] ? W'(-dir[a]) : W'(dir[a]);
      assign dmag_x = CMPW'(dmag);
      assign lim_x  = CMPW'(limit_ff);
      always_ff @(posedge clock) begin
         if (adv) begin
            den1_ff[a]   <= dmag;
            dneg1_ff[a]  <= dir[a][W-1];
            par1_ff[a]   <= dmag_x < lim_x;
            pmiss1_ff[a] <= (org[a] <= box_min_ff[a]) || (org[a] >= box_max_ff[a]);
         end
      end
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane1
      logic signed [W:0] bx, ox;
      logic              lt;
      assign bx = (l < NUM_AXES) ? (W+1)'(box_min_ff[l % NUM_AXES])
                                 : (W+1)'(box_max_ff[l % NUM_AXES]);
      assign ox = (W+1)'(org[l % NUM_AXES]);
      assign lt = bx < ox;
      always_ff @(posedge clock) begin
         if (adv) begin
            nneg1_ff[l] <= lt;
            num1_ff[l]  <= lt ? (W+1)'(ox - bx) : (W+1)'(bx - ox);
         end
      end
   end

   // ---------------- divider stages: index 0 prepared, index k after k bits
   logic                v_ff    [W+1];
   logic signed [W-1:0] t0_ff   [W+1];
   logic signed [W-1:0] t1_ff   [W+1];
   logic                par_ff  [W+1][NUM_AXES];
   logic                pmiss_ff[W+1][NUM_AXES];
   logic [W-1:0]        rem_ff  [W+1][NUM_LANES];
   logic [W-1:0]        low_ff  [W+1][NUM_LANES];
   logic [W-1:0]        q_ff    [W+1][NUM_LANES];
   logic [W-1:0]        den_ff  [W+1][NUM_LANES];
   logic                neg_ff  [W+1][NUM_LANES];
   logic                ovf_ff  [W+1][NUM_LANES];
   logic                zero_ff [W+1][NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else if (adv) v_ff[0] <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t0_ff[0] <= t0_1_ff;
         t1_ff[0] <= t1_1_ff;
         for (int a = 0; a < NUM_AXES; a++) begin
            par_ff[0][a]   <= par1_ff[a];
            pmiss_ff[0][a] <= pmiss1_ff[a];
         end
      end
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_prep
      logic [DVW-1:0] dv, hi_part;
      logic [W-1:0]   den;
      assign dv      = {num1_ff[l], {FRAC_BITS{1'b0}}};
      assign hi_part = dv >> W;
      assign den     = den1_ff[l % NUM_AXES];
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[0][l]  <= hi_part[W-1:0];
            low_ff[0][l]  <= dv[W-1:0];
            q_ff[0][l]    <= '0;
            den_ff[0][l]  <= den;
            // quotient would not fit in W bits (includes a zero divisor)
            ovf_ff[0][l]  <= hi_part >= DVW'(den);
            neg_ff[0][l]  <= nneg1_ff[l] ^ dneg1_ff[l % NUM_AXES];
            zero_ff[0][l] <= num1_ff[l] == '0;
         end
      end
   end

   for (genvar s = 0; s < W; s++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) v_ff[s+1] <= 1'b0;
         else if (adv) v_ff[s+1] <= v_ff[s];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            t0_ff[s+1] <= t0_ff[s];
            t1_ff[s+1] <= t1_ff[s];
            for (int a = 0; a < NUM_AXES; a++) begin
               par_ff[s+1][a]   <= par_ff[s][a];
               pmiss_ff[s+1][a] <= pmiss_ff[s][a];
            end
         end
      end

      for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
         logic [W:0] r2, diff;
         logic       ge;
         assign r2   = {rem_ff[s][l], low_ff[s][l][W-1]};
         assign diff = r2 - {1'b0, den_ff[s][l]};
         assign ge   = !diff[W];
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[s+1][l]  <= ge ? diff[W-1:0] : r2[W-1:0];
               low_ff[s+1][l]  <= {low_ff[s][l][W-2:0], 1'b0};
               q_ff[s+1][l]    <= {q_ff[s][l][W-2:0], ge};
               den_ff[s+1][l]  <= den_ff[s][l];
               neg_ff[s+1][l]  <= neg_ff[s][l];
               ovf_ff[s+1][l]  <= ovf_ff[s][l];
               zero_ff[s+1][l] <= zero_ff[s][l];
            end
         end
      end
   end

   // ---------------- saturation stage
   logic                vs_ff;
   logic signed [W-1:0] t0s_ff, t1s_ff;
   logic                pars_ff  [NUM_AXES];
   logic                pmisss_ff[NUM_AXES];
   logic signed [W-1:0] ts_ff    [NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) vs_ff <= 1'b0;
      else if (adv) vs_ff <= v_ff[W];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t0s_ff <= t0_ff[W];
         t1s_ff <= t1_ff[W];
         for (int a = 0; a < NUM_AXES; a++) begin
            pars_ff[a]   <= par_ff[W][a];
            pmisss_ff[a] <= pmiss_ff[W][a];
         end
      end
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_sat
      logic [W-1:0]        q;
      logic signed [W-1:0] t;
      assign q = q_ff[W][l];
      always_comb begin
         if (zero_ff[W][l])     t = '0;
         else if (ovf_ff[W][l]) t = neg_ff[W][l] ? SMIN : SMAX;
         else if (neg_ff[W][l]) t = (q > TOP) ? SMIN : W'(-q);
         else                   t = (q > TOP - 1'b1) ? SMAX : q;
      end
      always_ff @(posedge clock) begin
         if (adv) ts_ff[l] <= t;
      end
   end

   // ---------------- narrowing: one stage per axis, last one is the output
   logic                va_ff   [NUM_AXES];
   logic                miss_ff [NUM_AXES];
   logic signed [W-1:0] t0a_ff  [NUM_AXES];
   logic signed [W-1:0] t1a_ff  [NUM_AXES];
   logic signed [W-1:0] tpend_ff[NUM_AXES][NUM_LANES];
   logic                ppend_ff[NUM_AXES][NUM_AXES];
   logic                mpend_ff[NUM_AXES][NUM_AXES];

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_nar
      logic                v_i, miss_i, par_i, pm_i;
      logic signed [W-1:0] t0_i, t1_i, tn_r, tf_r, tn, tf, t0_n, t1_n;
      logic                miss_n;

      if (a == 0) begin : g_first
         assign v_i    = vs_ff;
         assign miss_i = 1'b0;
         assign t0_i   = t0s_ff;
         assign t1_i   = t1s_ff;
         assign par_i  = pars_ff[0];
         assign pm_i   = pmisss_ff[0];
         assign tn_r   = ts_ff[0];
         assign tf_r   = ts_ff[NUM_AXES];
      end else begin : g_next
         assign v_i    = va_ff[a-1];
         assign miss_i = miss_ff[a-1];
         assign t0_i   = t0a_ff[a-1];
         assign t1_i   = t1a_ff[a-1];
         assign par_i  = ppend_ff[a-1][a];
         assign pm_i   = mpend_ff[a-1][a];
         assign tn_r   = tpend_ff[a-1][a];
         assign tf_r   = tpend_ff[a-1][a+NUM_AXES];
      end

      always_comb begin
         // order the slab ends, then narrow the running interval (a parallel axis only checks the origin)
         tn     = (tn_r > tf_r) ? tf_r : tn_r;
         tf     = (tn_r > tf_r) ? tn_r : tf_r;
         t0_n   = t0_i;
         t1_n   = t1_i;
         miss_n = miss_i;
         if (par_i) begin
            miss_n = miss_i || pm_i;
         end else begin
            if (tn > t0_i) t0_n = tn;
            if (tf < t1_i) t1_n = tf;
            miss_n = miss_i || (((tn > t0_i) ? tn : t0_i) > ((tf < t1_i) ? tf : t1_i));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) va_ff[a] <= 1'b0;
         else if (adv) va_ff[a] <= v_i;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            miss_ff[a] <= miss_n;
            t0a_ff[a]  <= t0_n;
            t1a_ff[a]  <= t1_n;
            for (int l = 0; l < NUM_LANES; l++) begin
               tpend_ff[a][l] <= (a == 0) ? ts_ff[l] : tpend_ff[(a == 0) ? 0 : a-1][l];
            end
            for (int b = 0; b < NUM_AXES; b++) begin
               ppend_ff[a][b] <= (a == 0) ? pars_ff[b] : ppend_ff[(a == 0) ? 0 : a-1][b];
               mpend_ff[a][b] <= (a == 0) ? pmisss_ff[b] : mpend_ff[(a == 0) ? 0 : a-1][b];
            end
         end
      end
   end

   assign rsp_valid       = va_ff[NUM_AXES-1];
   assign rsp_hit         = !miss_ff[NUM_AXES-1];
   assign rsp_enter_param = miss_ff[NUM_AXES-1] ? '0 : t0a_ff[NUM_AXES-1];
   assign rsp_exit_param  = miss_ff[NUM_AXES-1] ? '0 : t1a_ff[NUM_AXES-1];

endmodule

@@ test/ray_box_slab_intersect_test.sv @@
// Self-checking test of the pipelined ray versus box slab intersection block.
`timescale 1ns / 1ps

module ray_box_slab_intersect_test;
   import rbsi_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int LATENCY = CW + 6;
   localparam int CYCLE_LIMIT = 600000;
   localparam longint unsigned TOP = 64'd1 << (CW - 1);

   typedef logic signed [CW-1:0] coord_type;

   typedef struct {
      coord_type origin [3];
      coord_type dir [3];
      coord_type t_start;
      coord_type t_end;
   } ray_type;

   typedef struct packed {
      logic      hit;
      coord_type enter_param;
      coord_type exit_param;
   } hit_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coord_type req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   coord_type req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   coord_type req_interval_start = '0, req_interval_end = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit;
   coord_type rsp_enter_param, rsp_exit_param;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr = '0;
   logic [CW-1:0] csr_wdata = '0;

   // box model and near-zero limit as last written
   coord_type box_lo [3];
   coord_type box_hi [3];
   logic [LIMIT_WIDTH-1:0] parallel_limit;

   hit_result_type pending_hits [$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_len = 0;
   longint cycles = 0;

   ray_box_slab_intersect DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_origin_x(req_origin_x), .req_origin_y(req_origin_y),
      .req_origin_z(req_origin_z),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .req_interval_start(req_interval_start), .req_interval_end(req_interval_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .rsp_enter_param(rsp_enter_param), .rsp_exit_param(rsp_exit_param),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ((bound - origin) << 16) / dir, magnitude truncated, then saturated
   function automatic coord_type slab_distance(longint bound, longint org, longint d);
      longint unsigned num, den, q;
      logic [63:0] r;
      bit neg_num, neg;
      neg_num = bound < org;
      num = neg_num ? longint'(org - bound) : longint'(bound - org);
      den = (d < 0) ? -d : d;
      neg = neg_num != (d < 0);
      if (num == 0) return '0;
      if (den == 0) begin
         neg = neg_num;
         q = '1;
      end else begin
         q = (num << FRAC_BITS) / den;
      end
      if (neg) begin
         if (q > TOP) q = TOP;
         r = 64'd0 - q;
      end else begin
         if (q > TOP - 1) q = TOP - 1;
         r = q;
      end
      return r[CW-1:0];
   endfunction

   function automatic hit_result_type trace_ray(ray_type r);
      hit_result_type res;
      longint t0, t1, tn, tf, s, o, d;
      longint unsigned mag;
      t0 = r.t_start;
      t1 = r.t_end;
      res = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         o = r.origin[i];
         d = r.dir[i];
         mag = (d < 0) ? -d : d;
         if (mag < longint'(parallel_limit)) begin
            if (o <= longint'(box_lo[i]) || o >= longint'(box_hi[i])) return res;
         end else begin
            tn = slab_distance(box_lo[i], o, d);
            tf = slab_distance(box_hi[i], o, d);
            if (tn > tf) begin
               s = tn; tn = tf; tf = s;
            end
            if (tn > t0) t0 = tn;
            if (tf < t1) t1 = tf;
            if (t0 > t1) return res;
         end
      end
      res.hit = 1'b1;
      res.enter_param = t0[CW-1:0];
      res.exit_param = t1[CW-1:0];
      return res;
   endfunction

   // result checker
   always @(posedge clock) begin
      hit_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result hit=%0b", rsp_hit);
         end else begin
            want = pending_hits.pop_front();
            if (rsp_hit !== want.hit || rsp_enter_param !== want.enter_param ||
                rsp_exit_param !== want.exit_param) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: want hit=%0b enter=%0d exit=%0d, ",
                            "got hit=%0b enter=%0d exit=%0d"},
                           want.hit, want.enter_param, want.exit_param,
                           rsp_hit, rsp_enter_param, rsp_exit_param);
            end
         end
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            n = hold_len;
            hold_len = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic write_reg(csr_addr_type idx, logic [CW-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      if (idx < CSR_BOX_MAX_X) box_lo[idx] = val;
      else if (idx < CSR_NEAR_ZERO) box_hi[idx - CSR_BOX_MAX_X] = val;
      else parallel_limit = val[LIMIT_WIDTH-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_box(coord_type lx, coord_type ly, coord_type lz, coord_type hx,
                          coord_type hy, coord_type hz, logic [LIMIT_WIDTH-1:0] lim);
      write_reg(CSR_BOX_MIN_X, lx);
      write_reg(CSR_BOX_MIN_Y, ly);
      write_reg(CSR_BOX_MIN_Z, lz);
      write_reg(CSR_BOX_MAX_X, hx);
      write_reg(CSR_BOX_MAX_Y, hy);
      write_reg(CSR_BOX_MAX_Z, hz);
      write_reg(CSR_NEAR_ZERO, {1'b0, lim});
   endtask

   // drop valid, then hold until every expected result is back
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic send_ray(ray_type r);
      bit ok;
      req_origin_x <= r.origin[0];
      req_origin_y <= r.origin[1];
      req_origin_z <= r.origin[2];
      req_dir_x <= r.dir[0];
      req_dir_y <= r.dir[1];
      req_dir_z <= r.dir[2];
      req_interval_start <= r.t_start;
      req_interval_end <= r.t_end;
      req_valid <= 1'b1;
      do begin
         @(negedge clock);
         ok = req_ready;
         @(posedge clock);
      end while (!ok);
      pending_hits.push_back(trace_ray(r));
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   function automatic ray_type make_ray(coord_type ox, coord_type oy, coord_type oz,
                                        coord_type dx, coord_type dy, coord_type dz,
                                        coord_type ts, coord_type te);
      ray_type r;
      r.origin[0] = ox; r.origin[1] = oy; r.origin[2] = oz;
      r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
      r.t_start = ts; r.t_end = te;
      return r;
   endfunction

   // mostly coordinates near the box scale, some extremes and raw noise
   function automatic coord_type pick_coord(int scale);
      int sel;
      sel = $urandom_range(99);
      if (sel < 60) return coord_type'($signed($urandom_range(2 * scale)) - scale) <<< 12;
      if (sel < 68) return coord_type'($urandom_range(3) == 0 ? 32'h8000_0000 :
                                       $urandom_range(1) ? 32'h7FFF_FFFF : 32'h0);
      if (sel < 76) return coord_type'($signed($urandom_range(64)) - 32);
      return coord_type'($urandom);
   endfunction

   function automatic ray_type random_ray();
      ray_type r;
      for (int i = 0; i < 3; i++) begin
         r.origin[i] = pick_coord(64);
         r.dir[i] = pick_coord(32);
      end
      if ($urandom_range(3) != 0) begin
         r.t_start = coord_type'($signed($urandom_range(16)) - 4) <<< 16;
         r.t_end = r.t_start + (coord_type'($urandom_range(1 << 24)));
         if ($urandom_range(9) == 0) r.t_end = 32'h7FFF_FFFF;
      end else begin
         r.t_start = pick_coord(64);
         r.t_end = pick_coord(64);
      end
      return r;
   endfunction

   task automatic test_reset_box();
      send_ray(make_ray(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 32'h7FFF_FFFF));
      send_ray(make_ray(5, 5, 5, 0, 0, 0, 0, 32'h10000));
      wait_drain();
   endtask

   task automatic test_directed();
      coord_type one, mn, mx;
      one = 32'h10000; mn = 32'h8000_0000; mx = 32'h7FFF_FFFF;
      set_box(-one, -one, -one, one, one, one, 31'd1);
      // axis-aligned hit from outside, both signs
      send_ray(make_ray(-(one <<< 2), 0, 0, one, 0, 0, 0, mx));
      send_ray(make_ray(one <<< 2, 0, 0, -one, 0, 0, 0, mx));
      // parallel inside, on the face, outside
      send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, one));
      send_ray(make_ray(one, 0, 0, 0, one, 0, 0, mx));
      send_ray(make_ray(one <<< 1, 0, 0, 0, one, 0, 0, mx));
      // only parallel axes with a reversed interval
      send_ray(make_ray(0, 0, 0, 0, 0, 0, one, -one));
      // diagonal, narrowing then miss by interval
      send_ray(make_ray(-(one <<< 1), -(one <<< 1), -(one <<< 1), one, one, one, 0, mx));
      send_ray(make_ray(-(one <<< 1), 0, 0, one, 0, 0, 0, one >>> 1));
      // saturation: tiny direction, extreme origins
      send_ray(make_ray(mn, 0, 0, 1, 0, 0, mn, mx));
      send_ray(make_ray(mx, mx, mx, -1, -1, -1, mn, mx));
      send_ray(make_ray(mn, mn, mn, mn, mn, mn, mn, mn));
      send_ray(make_ray(mx, mn, mx, mx, mn, mx, mx, mx));
      send_ray(make_ray(-1, -1, -1, -1, -1, -1, -1, -1));
      wait_drain();
      // zero limit: a zero direction is not parallel
      write_reg(CSR_NEAR_ZERO, '0);
      send_ray(make_ray(0, 0, 0, 0, 0, 0, mn, mx));
      send_ray(make_ray(one <<< 1, 0, 0, 0, one, 0, mn, mx));
      send_ray(make_ray(one, 0, 0, 0, 0, one, mn, mx));
      wait_drain();
      // largest limit, reversed box, extreme box
      set_box(one, one, one, -one, -one, -one, 31'h7FFF_FFFF);
      send_ray(make_ray(0, 0, 0, one, 0, 0, mn, mx));
      send_ray(make_ray(0, 0, 0, mn, mn, mn, mn, mx));
      wait_drain();
      set_box(mn, mn, mn, mx, mx, mx, '0);
      send_ray(make_ray(0, 0, 0, one, -one, 1, mn, mx));
      send_ray(make_ray(mx, mn, 0, 1, -1, 0, mn, mx));
      wait_drain();
   endtask

   task automatic random_box();
      coord_type a, b;
      logic [LIMIT_WIDTH-1:0] lim;
      for (int i = 0; i < 3; i++) begin
         a = pick_coord(64);
         b = pick_coord(64);
         if ($urandom_range(3) != 0 && a > b) begin
            write_reg(csr_addr_type'(CSR_BOX_MIN_X + i), b);
            write_reg(csr_addr_type'(CSR_BOX_MAX_X + i), a);
         end else begin
            write_reg(csr_addr_type'(CSR_BOX_MIN_X + i), a);
            write_reg(csr_addr_type'(CSR_BOX_MAX_X + i), b);
         end
      end
      case ($urandom_range(4))
         0: lim = '0;
         1: lim = 31'h7FFF_FFFF;
         2: lim = LIMIT_WIDTH'($urandom);
         default: lim = LIMIT_WIDTH'($urandom_range(1 << 14));
      endcase
      write_reg(CSR_NEAR_ZERO, {1'b0, lim});
   endtask

   task automatic test_random_phase(int idle, int stall, int count);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) begin
            wait_drain();
            random_box();
         end
         send_ray(random_ray());
      end
      wait_drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_len = 300;
      for (int i = 0; i < 120; i++) send_ray(random_ray());
      // pause until everything is back, then continue
      wait_drain();
      for (int i = 0; i < 30; i++) send_ray(random_ray());
      wait_drain();
   endtask

   initial begin
      for (int i = 0; i < 3; i++) begin
         box_lo[i] = 32'h7FFF_FFFF;
         box_hi[i] = 32'h8000_0000;
      end
      parallel_limit = 1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_box();
      test_directed();
      test_random_phase(0, 0, 320);
      test_random_phase(58, 0, 320);
      test_random_phase(0, 58, 320);
      test_random_phase(9, 9, 320);
      test_backpressure();
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && pending_hits.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
